// ===== rtl/cbard_pkg.sv =====
`timescale 1ns / 1ps

package cbard_pkg;

	// Register indexes of the configuration port.
	localparam logic CfgIdxShift = 1'b0;
	localparam logic CfgIdxEmit  = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [3:0] ShiftReset = 4'd8;
	localparam logic       EmitReset  = 1'b1;

	// Offset removed from the signed running sample before the shift.
	localparam logic [15:0] SampleOffset = 16'h0040;

	// Class of the word at the input, decoded against the run state.
	typedef enum logic [2:0] {
		KIND_SEED_EMIT  = 3'd0,
		KIND_SEED_QUIET = 3'd1,
		KIND_PAIR       = 3'd2,
		KIND_ABS        = 3'd3,
		KIND_OPEN       = 3'd4,
		KIND_REPEAT     = 3'd5
	} byte_kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;      // input word accepted, update the run state
		logic second;    // emit the second sample of a nibble pair
		logic repeat_s;  // emit one more sample of a repeat run
		logic out_load;  // load the output register
	} cbard_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		byte_kind_t kind;
		logic       rep_first_last;  // repeat run of a single sample
		logic       rep_last;        // one repeat sample left
	} cbard_status_t;

	// Sign-extend an 8-bit sample, remove the offset, shift, wrap to 16 bits.
	function automatic logic [15:0] to_pcm(input logic [7:0] s, input logic [3:0] shift);
		logic [15:0] v;
		v = {{8{s[7]}}, s} - SampleOffset;
		return v << shift;
	endfunction

	// Add a signed nibble delta to a sample with 8-bit wrap.
	function automatic logic [7:0] add_nibble(input logic [7:0] s, input logic [3:0] n);
		return s + {{4{n[3]}}, n};
	endfunction

endpackage

// ===== rtl/cbard_ctrl.sv =====
`timescale 1ns / 1ps

module cbard_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  logic                     out_ready,
	input  cbard_pkg::cbard_status_t status,
	output cbard_pkg::cbard_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SECOND = 3'b010,
		ST_REPEAT = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;
	logic   produces;

	// The output register can take a new word when empty or being emptied.
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && slot_free;
	assign out_valid = out_valid_q;

	// Which input words cause a sample right away.
	always_comb begin
		unique case (status.kind) inside
			cbard_pkg::KIND_SEED_EMIT, cbard_pkg::KIND_PAIR,
			cbard_pkg::KIND_ABS, cbard_pkg::KIND_REPEAT: produces = 1'b1;
			default: produces = 1'b0;
		endcase
	end

	// Next state and commands.
	always_comb begin
		state_d      = state_q;
		cmd.take     = 1'b0;
		cmd.second   = 1'b0;
		cmd.repeat_s = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && slot_free) begin
					cmd.take = 1'b1;
					if (status.kind == cbard_pkg::KIND_PAIR) begin
						state_d = ST_SECOND;
					end else if (status.kind == cbard_pkg::KIND_REPEAT
							&& !status.rep_first_last) begin
						state_d = ST_REPEAT;
					end
				end
			end
			ST_SECOND: begin
				if (slot_free) begin
					cmd.second = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_REPEAT: begin
				if (slot_free) begin
					cmd.repeat_s = 1'b1;
					if (status.rep_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
		cmd.out_load = (cmd.take && produces) || cmd.second || cmd.repeat_s;
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/cbard_dp.sv =====
`timescale 1ns / 1ps

module cbard_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [7:0]               code_byte,
	input  logic                     block_start,
	input  logic                     cfg_valid,
	input  logic                     cfg_index,
	input  logic [3:0]               cfg_data,
	input  cbard_pkg::cbard_cmd_t    cmd,
	output cbard_pkg::cbard_status_t status,
	output logic signed [15:0]       sample,
	output logic                     last_of_run
);

	logic [3:0]  shift_q;
	logic        emit_q;
	logic [7:0]  running_q;
	logic [6:0]  pairs_left_q;
	logic [5:0]  rep_left_q;
	logic [15:0] sample_q;
	logic        last_q;
	logic [7:0]  s1;
	logic [7:0]  s2;
	logic [7:0]  pcm_src;
	logic        first_last;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= cbard_pkg::ShiftReset;
			emit_q  <= cbard_pkg::EmitReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cbard_pkg::CfgIdxShift: shift_q <= cfg_data;
				cbard_pkg::CfgIdxEmit:  emit_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign first_last = (code_byte[5:0] == 6'd0);

	// Classify the input word; an open pair run takes any non-seed word.
	always_comb begin
		status.rep_first_last = first_last;
		status.rep_last       = (rep_left_q == 6'd1);
		if (block_start) begin
			status.kind = emit_q ? cbard_pkg::KIND_SEED_EMIT : cbard_pkg::KIND_SEED_QUIET;
		end else if (pairs_left_q != 7'd0) begin
			status.kind = cbard_pkg::KIND_PAIR;
		end else if (!code_byte[7]) begin
			status.kind = cbard_pkg::KIND_ABS;
		end else if (!code_byte[6]) begin
			status.kind = cbard_pkg::KIND_OPEN;
		end else begin
			status.kind = cbard_pkg::KIND_REPEAT;
		end
	end

	// Both samples of a nibble pair.
	assign s1 = cbard_pkg::add_nibble(running_q, code_byte[7:4]);
	assign s2 = cbard_pkg::add_nibble(s1, code_byte[3:0]);

	// Run state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= 8'd0;
			pairs_left_q <= 7'd0;
			rep_left_q   <= 6'd0;
		end else if (cmd.take) begin
			unique case (status.kind)
				cbard_pkg::KIND_SEED_EMIT, cbard_pkg::KIND_SEED_QUIET,
				cbard_pkg::KIND_ABS: begin
					running_q    <= code_byte;
					pairs_left_q <= 7'd0;
				end
				cbard_pkg::KIND_PAIR: begin
					running_q    <= s2;
					pairs_left_q <= pairs_left_q - 7'd1;
				end
				cbard_pkg::KIND_OPEN: begin
					pairs_left_q <= {1'b0, code_byte[5:0]} + 7'd1;
				end
				cbard_pkg::KIND_REPEAT: begin
					rep_left_q <= code_byte[5:0];
				end
				default: ;
			endcase
		end else if (cmd.repeat_s) begin
			rep_left_q <= rep_left_q - 6'd1;
		end
	end

	// Source of the next output sample.
	always_comb begin
		pcm_src = running_q;
		if (cmd.take) begin
			unique case (status.kind)
				cbard_pkg::KIND_PAIR:   pcm_src = s1;
				cbard_pkg::KIND_REPEAT: pcm_src = running_q;
				default:                pcm_src = code_byte;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sample_q <= cbard_pkg::to_pcm(pcm_src, shift_q);
			if (cmd.take) begin
				if (status.kind == cbard_pkg::KIND_PAIR) begin
					last_q <= 1'b0;
				end else if (status.kind == cbard_pkg::KIND_REPEAT) begin
					last_q <= first_last;
				end else begin
					last_q <= 1'b1;
				end
			end else if (cmd.repeat_s) begin
				last_q <= status.rep_last;
			end else begin
				last_q <= 1'b1;
			end
		end
	end

	assign sample      = sample_q;
	assign last_of_run = last_q;

endmodule

// ===== rtl/control_byte_adpcm_rle_decoder_core.sv =====
`timescale 1ns / 1ps

// Control-byte ADPCM/RLE decoder.
// Input channel (in_valid/in_ready) carries one compressed word per item:
// code_byte and block_start, which marks the seed word of a block.
// Output channel (out_valid/out_ready) carries one PCM sample per word with
// last_of_run set on the final sample caused by an input word.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 writes
// sample_shift from cfg_data, index 1 writes emit_seed from cfg_data[0];
// write only while the decoder is idle.
// The first sample of a word is registered and appears in the cycle after
// the word is accepted. A nibble-pair word yields two samples, a repeat word
// 1 to 64 samples, any other word at most one; the controller emits one
// sample per cycle through a single output register while the receiver
// accepts, and run openers and quiet seeds cause no sample.
// Reset clears the running sample and the run state and sets sample_shift
// to 8 and emit_seed to 1. When the receiver stalls, the output word holds
// and the decoder stops, taking no new word until the output register frees.
module control_byte_adpcm_rle_decoder_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         code_byte,
	input  logic               block_start,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample,
	output logic               last_of_run,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [3:0]         cfg_data
);

	cbard_pkg::cbard_cmd_t    cmd;
	cbard_pkg::cbard_status_t status;

	assign cfg_ready = 1'b1;

	// Controller state machine.
	cbard_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Sample datapath and configuration registers.
	cbard_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.code_byte   (code_byte),
		.block_start (block_start),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.status      (status),
		.sample      (sample),
		.last_of_run (last_of_run)
	);

	// While a sample that is not the last of its word is shown, more samples
	// of that word are pending, so no new input word may be taken.
	a_no_take_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> !in_ready)
		else $error("input accepted while a run is still being emitted");

	// A seed word either emits a single final sample or leaves the output empty.
	a_seed_single: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && block_start |=> !out_valid || last_of_run)
		else $error("seed word produced a non-final sample");

endmodule
